[rtl/core/ablr_pkg.sv]
// Shared constants and types for the alpha-blended line raster core.
package ablr_pkg;

	localparam int FB_WIDTH  = 256;
	localparam int FB_HEIGHT = 256;
	localparam int FB_SIZE   = FB_WIDTH * FB_HEIGHT;
	localparam int ADDR_W    = $clog2(FB_SIZE);
	localparam int PIX_W     = 24;
	localparam int COLOR_W   = 32;
	localparam int COORD_W   = 8;
	localparam int CNT_W     = 17;
	localparam int CNT_MAX   = (1 << CNT_W) - 1;

	localparam logic [31:0]       FB_W_L     = 32'(FB_WIDTH);
	localparam logic [31:0]       FB_H_L     = 32'(FB_HEIGHT);
	localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(FB_SIZE - 1);
	localparam logic [CNT_W-1:0]  FILL_COUNT =
		(FB_SIZE > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(FB_SIZE);

	typedef enum logic [1:0] {
		MODE_LINE = 2'd0,
		MODE_PLOT = 2'd1,
		MODE_READ = 2'd2,
		MODE_FILL = 2'd3
	} mode_t;

	// Segment endpoints loaded into the line walker.
	typedef struct packed {
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
	} seg_t;

	// Current pixel offered by the line walker.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} px_t;

endpackage

[rtl/core/alpha_blended_line_raster_core.sv]
// Top level: command sequencer, pixel read-modify-write pipe and framebuffer.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | mode, start_x, start_y, end_x, end_y, color
//  out     | out_valid / out_ready| pixel_value, pixels_written
//
// Pace: a line walks one pixel per cycle (one framebuffer read and one
// blended write per pixel, overlapped through one pipe stage), up to 256 pixels.
// Plot and read handle a single pixel; fill walks all FB_SIZE pixels, one pixel each.
// The single-read, single-write framebuffer port pair sets the one-pixel pace.
// Reset: a clearing pass writes black to all FB_SIZE (65536) pixels, one per
// cycle; in_ready stays low until it ends.
// Stalls: a finished result waits in the output register while the next
// request is accepted; a later result holds in the done state until taken.
module alpha_blended_line_raster_core import ablr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [COORD_W-1:0]   start_x,
	input  logic [COORD_W-1:0]   start_y,
	input  logic [COORD_W-1:0]   end_x,
	input  logic [COORD_W-1:0]   end_y,
	input  logic [COLOR_W-1:0]   color,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     pixel_value,
	output logic [CNT_W-1:0]     pixels_written
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_WALK  = 6'b000100,
		ST_FILL  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t              state_q;
	mode_t               in_mode;
	mode_t               mode_q;
	logic [COLOR_W-1:0]  color_q;
	logic [ADDR_W-1:0]   sweep_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PIX_W-1:0]    value_q;
	logic                out_valid_q;
	logic [PIX_W-1:0]    pixel_value_q;
	logic [CNT_W-1:0]    pixels_written_q;

	// read-modify-write pipe stage
	logic                vld_s1;
	logic                wr_s1;
	logic [ADDR_W-1:0]   addr_s1;

	logic                accept;
	logic                result_load;
	seg_t                seg;
	px_t                 px;
	logic                adv;
	logic                px_in_fb;
	logic [ADDR_W-1:0]   px_addr;
	logic                issue;
	logic                issue_wr;
	logic [ADDR_W-1:0]   rd_addr;
	logic [PIX_W-1:0]    rd_data;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [PIX_W-1:0]    wdata;
	logic [PIX_W-1:0]    blended;

	assign in_mode     = mode_t'(mode);
	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign result_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Plot and read walk a segment of one point.
	always_comb begin
		seg.x0 = start_x;
		seg.y0 = start_y;
		if (in_mode == MODE_LINE) begin
			seg.x1 = end_x;
			seg.y1 = end_y;
		end else begin
			seg.x1 = start_x;
			seg.y1 = start_y;
		end
	end

	ablr_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.adv    (adv),
		.seg    (seg),
		.px     (px)
	);

	// Drop pixels that fall outside a buffer narrower than the coordinate range.
	assign px_in_fb = (32'(px.x) < FB_W_L) && (32'(px.y) < FB_H_L);
	assign px_addr  = ADDR_W'(32'(px.y) * FB_W_L + 32'(px.x));

	// Issue one framebuffer read per cycle while walking or filling.
	always_comb begin
		adv      = 1'b0;
		issue    = 1'b0;
		issue_wr = 1'b0;
		rd_addr  = px_addr;
		case (state_q)
			ST_WALK: begin
				adv      = 1'b1;
				issue    = px_in_fb;
				issue_wr = (mode_q != MODE_READ);
			end
			ST_FILL: begin
				issue    = 1'b1;
				issue_wr = 1'b1;
				rd_addr  = sweep_q;
			end
			default: begin
				adv = 1'b0;
			end
		endcase
	end

	ablr_blend u_blend (
		.old_px (rd_data),
		.color  (color_q),
		.new_px (blended)
	);

	// Write back the blended pixel, or black during the clearing pass.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = sweep_q;
			wdata = '0;
		end else begin
			we    = vld_s1 && wr_s1;
			waddr = addr_s1;
			wdata = blended;
		end
	end

	ablr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (FB_SIZE)
	) u_fb (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sweep_q == LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						sweep_q <= '0;
						state_q <= (in_mode == MODE_FILL) ? ST_FILL : ST_WALK;
					end
				end
				ST_WALK: begin
					if (px.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_FILL: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (result_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command, pipe and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= in_mode;
			color_q <= color;
			value_q <= '0;
			cnt_q   <= (in_mode == MODE_FILL) ? FILL_COUNT : '0;
		end else begin
			if ((state_q == ST_WALK) && issue && issue_wr) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (vld_s1 && !wr_s1) begin
				value_q <= rd_data;
			end
		end
		wr_s1   <= issue_wr;
		addr_s1 <= rd_addr;
		if (result_load) begin
			pixel_value_q    <= value_q;
			pixels_written_q <= cnt_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_value    = pixel_value_q;
	assign pixels_written = pixels_written_q;

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		issue && we |-> (rd_addr != waddr))
		else $error("framebuffer read and write hit the same pixel");

	a_pipe_empty_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !vld_s1)
		else $error("request accepted with a pixel still in flight");

	a_value_or_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_value == '0) || (pixels_written == '0))
		else $error("result carries both a read value and a pixel count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixels_written <= CNT_W'(256)) || (pixels_written == FILL_COUNT))
		else $error("pixel count out of range");

endmodule

[rtl/core/ablr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module ablr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/ablr_blend.sv]
// Per-channel alpha blend of one RGB pixel with an ARGB source color.
module ablr_blend import ablr_pkg::*; (
	input  logic [PIX_W-1:0]   old_px,
	input  logic [COLOR_W-1:0] color,
	output logic [PIX_W-1:0]   new_px
);

	logic [7:0]  alpha;
	logic [7:0]  inv_alpha;
	logic [15:0] mix [3];
	logic [15:0] adj [3];

	assign alpha     = color[31:24];
	assign inv_alpha = 8'd255 - alpha;

	// floor(x / 255) for x below 65280 is (x + 1 + (x >> 8)) >> 8.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mix[i] = 16'(old_px[8*i +: 8]) * 16'(inv_alpha)
				+ 16'(color[8*i +: 8]) * 16'(alpha);
			adj[i] = mix[i] + 16'd1 + 16'(mix[i][15:8]);
			new_px[8*i +: 8] = adj[i][15:8];
		end
	end

endmodule

[rtl/core/ablr_walker.sv]
// Line walker: steps the major axis and tracks the minor axis with a remainder.
module ablr_walker import ablr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic adv,
	input  seg_t seg,
	output px_t  px
);

	logic [COORD_W-1:0] dx, dy, d_new;
	logic               y_major;
	logic               swap_end;
	logic [COORD_W-1:0] ax, ay, bx, by;
	logic [COORD_W-1:0] maj_new, min_new, min_end;
	logic signed [8:0]  v_new;

	logic [COORD_W-1:0] maj_q, min_q, d_q, left_q, r_q;
	logic signed [8:0]  v_q;
	logic               y_major_q;
	logic               active_q;

	logic signed [9:0]  r_sum, r_fix, d_ext;
	logic [COORD_W-1:0] min_next;

	// Pick the axis and the lower end of the segment.
	always_comb begin
		dx = (seg.x1 > seg.x0) ? seg.x1 - seg.x0 : seg.x0 - seg.x1;
		dy = (seg.y1 > seg.y0) ? seg.y1 - seg.y0 : seg.y0 - seg.y1;
		y_major = dy > dx;
		if (y_major) begin
			swap_end = seg.y0 > seg.y1;
			d_new    = dy;
		end else begin
			swap_end = seg.x0 > seg.x1;
			d_new    = dx;
		end
		if (swap_end) begin
			ax = seg.x1; ay = seg.y1; bx = seg.x0; by = seg.y0;
		end else begin
			ax = seg.x0; ay = seg.y0; bx = seg.x1; by = seg.y1;
		end
		maj_new = y_major ? ay : ax;
		min_new = y_major ? ax : ay;
		min_end = y_major ? bx : by;
		v_new   = $signed({1'b0, min_end}) - $signed({1'b0, min_new});
	end

	// Shared step unit: add the minor extent, correct once by the major extent.
	always_comb begin
		d_ext = $signed({2'b00, d_q});
		r_sum = $signed({2'b00, r_q}) + $signed({v_q[8], v_q});
		if (r_sum < 0) begin
			r_fix    = r_sum + d_ext;
			min_next = min_q - 8'd1;
		end else if (r_sum >= d_ext) begin
			r_fix    = r_sum - d_ext;
			min_next = min_q + 8'd1;
		end else begin
			r_fix    = r_sum;
			min_next = min_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			maj_q     <= maj_new;
			min_q     <= min_new;
			d_q       <= d_new;
			left_q    <= d_new;
			r_q       <= '0;
			v_q       <= v_new;
			y_major_q <= y_major;
		end else if (adv) begin
			maj_q  <= maj_q + 8'd1;
			min_q  <= min_next;
			r_q    <= r_fix[7:0];
			left_q <= left_q - 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= 1'b1;
		end else if (adv && px.last) begin
			active_q <= 1'b0;
		end
	end

	assign px.x    = y_major_q ? min_q : maj_q;
	assign px.y    = y_major_q ? maj_q : min_q;
	assign px.last = (left_q == '0);

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && (d_q != '0) |-> (r_q < d_q))
		else $error("walker remainder left its range");

	a_adv_when_active: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> active_q)
		else $error("walker advanced without a loaded segment");

endmodule

[dv/alpha_blended_line_raster_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the alpha-blended line raster core with a framebuffer shadow.
module alpha_blended_line_raster_core_tb;
	import ablr_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 4;
	localparam int N_RANDOM       = 1625;
	localparam int MAX_RAND_FILLS = 2;
	localparam int HOT_N          = 8;
	localparam int COORD_MAX      = (1 << COORD_W) - 1;
	localparam int SEND_GAP_MAX   = 15;
	localparam int STALL_RUN_MAX  = 20;
	localparam int TAIL_CYCLES    = 300;

	// One draw request as the sender drives it.
	typedef struct {
		mode_t              op;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [COLOR_W-1:0] argb;
	} raster_req_t;

	// What the core must return for one request.
	typedef struct {
		mode_t            op;
		logic [PIX_W-1:0] rgb;
		logic [CNT_W-1:0] count;
	} raster_result_t;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic [1:0]         mode           = '0;
	logic [COORD_W-1:0] start_x        = '0;
	logic [COORD_W-1:0] start_y        = '0;
	logic [COORD_W-1:0] end_x          = '0;
	logic [COORD_W-1:0] end_y          = '0;
	logic [COLOR_W-1:0] color          = '0;
	logic               out_valid;
	logic               out_ready      = 1'b0;
	logic [PIX_W-1:0]   pixel_value;
	logic [CNT_W-1:0]   pixels_written;

	// Requests waiting to be driven, and results the core still owes us.
	raster_req_t    pending_reqs[$];
	raster_result_t expected_results[$];

	// Shadow copy of the framebuffer, advanced as each request is accepted.
	logic [PIX_W-1:0] shadow_fb [FB_SIZE];

	// Recently touched points; reads aim here so they see blended pixels.
	int hot_x [HOT_N];
	int hot_y [HOT_N];
	int hot_wr;

	int          err_count;
	int          result_idx;
	longint      work_budget;
	longint      cycle_cnt;
	longint      cycle_limit = 64'd50_000_000;

	raster_req_t    cur_req;
	raster_result_t want;
	int             burst_left;
	int             gap_left;
	int             stall_kind;
	int             stall_left;

	alpha_blended_line_raster_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.start_x        (start_x),
		.start_y        (start_y),
		.end_x          (end_x),
		.end_y          (end_y),
		.color          (color),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_value    (pixel_value),
		.pixels_written (pixels_written)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Hold reset for a few cycles, then release it away from the active edge.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------
	// Shadow framebuffer arithmetic
	// ------------------------------------------------------------------

	// Blend each channel as floor((old*(255-a) + new*a) / 255).
	function automatic logic [PIX_W-1:0] blend_rgb(logic [PIX_W-1:0] under,
			logic [COLOR_W-1:0] argb);
		int unsigned a, o, n;
		int c;
		logic [PIX_W-1:0] mix;
		a = argb[31:24];
		for (c = 0; c < 3; c++) begin
			o = under[c*8 +: 8];
			n = argb[c*8 +: 8];
			mix[c*8 +: 8] = 8'((o * (255 - a) + n * a) / 255);
		end
		return mix;
	endfunction

	// Blend one pixel; pixels off the buffer are skipped and not counted.
	function automatic int unsigned shadow_plot(int x, int y, logic [COLOR_W-1:0] argb);
		int idx;
		if (x < 0 || y < 0 || x >= FB_WIDTH || y >= FB_HEIGHT) return 0;
		idx = x + y * FB_WIDTH;
		shadow_fb[idx] = blend_rgb(shadow_fb[idx], argb);
		return 1;
	endfunction

	function automatic int floor_div(int num, int den);
		if (num >= 0) return num / den;
		return -((-num + den - 1) / den);
	endfunction

	// Walk the major axis from its lower end, both endpoints included.
	// Equal extents walk the diagonal from the lower-x end.
	function automatic int unsigned shadow_line(int x0, int y0, int x1, int y1,
			logic [COLOR_W-1:0] argb);
		int dx, dy, lx, ly, span, ty, dir, k;
		int unsigned hits;
		hits = 0;
		dx = (x1 > x0) ? x1 - x0 : x0 - x1;
		dy = (y1 > y0) ? y1 - y0 : y0 - y1;
		if (dx > dy) begin
			if (x0 <= x1) begin lx = x0; ly = y0; span = y1 - y0; end
			else begin lx = x1; ly = y1; span = y0 - y1; end
			for (k = 0; k <= dx; k++)
				hits += shadow_plot(lx + k, ly + floor_div(span * k, dx), argb);
		end else if (dy > dx) begin
			if (y0 <= y1) begin lx = x0; ly = y0; span = x1 - x0; end
			else begin lx = x1; ly = y1; span = x0 - x1; end
			for (k = 0; k <= dy; k++)
				hits += shadow_plot(lx + floor_div(span * k, dy), ly + k, argb);
		end else begin
			if (x0 >= x1) begin lx = x1; ly = y1; ty = y0; end
			else begin lx = x0; ly = y0; ty = y1; end
			dir = (ly < ty) ? 1 : -1;
			for (k = 0; k <= dx; k++)
				hits += shadow_plot(lx + k, ly + dir * k, argb);
		end
		return hits;
	endfunction

	// Apply one accepted request to the shadow and return what the core owes.
	function automatic raster_result_t apply_request(raster_req_t rq);
		raster_result_t res;
		int i;
		res.op    = rq.op;
		res.rgb   = '0;
		res.count = '0;
		case (rq.op)
			MODE_LINE: res.count = CNT_W'(shadow_line(rq.sx, rq.sy, rq.ex, rq.ey, rq.argb));
			MODE_PLOT: res.count = CNT_W'(shadow_plot(rq.sx, rq.sy, rq.argb));
			MODE_READ: begin
				if (int'(rq.sx) < FB_WIDTH && int'(rq.sy) < FB_HEIGHT)
					res.rgb = shadow_fb[int'(rq.sx) + int'(rq.sy) * FB_WIDTH];
			end
			default: begin
				for (i = 0; i < FB_SIZE; i++)
					shadow_fb[i] = blend_rgb(shadow_fb[i], rq.argb);
				res.count = CNT_W'((FB_SIZE > CNT_MAX) ? CNT_MAX : FB_SIZE);
			end
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic int near_coord(int c, int reach);
		int v;
		v = c + int'($urandom_range(0, 2 * reach)) - reach;
		return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	// Alpha lands on fully transparent, fully opaque or anything between.
	function automatic logic [COLOR_W-1:0] rand_argb();
		logic [7:0] a;
		case ($urandom_range(0, 3))
			0: a = 8'h00;
			1: a = 8'hFF;
			default: a = 8'($urandom);
		endcase
		return {a, 24'($urandom)};
	endfunction

	// Queue one request, grow the cycle budget and remember where it drew.
	task automatic queue_req(mode_t op, int sx, int sy, int ex, int ey,
			logic [COLOR_W-1:0] argb);
		raster_req_t rq;
		int dx, dy;
		rq.op   = op;
		rq.sx   = COORD_W'(sx);
		rq.sy   = COORD_W'(sy);
		rq.ex   = COORD_W'(ex);
		rq.ey   = COORD_W'(ey);
		rq.argb = argb;
		pending_reqs.push_back(rq);
		dx = (ex > sx) ? ex - sx : sx - ex;
		dy = (ey > sy) ? ey - sy : sy - ey;
		case (op)
			MODE_LINE: work_budget += ((dx > dy) ? dx : dy) + 4;
			MODE_FILL: work_budget += FB_SIZE + 3;
			default:   work_budget += 4;
		endcase
		// Allow for the sender's longest gap and two back-to-back receiver stalls.
		work_budget += SEND_GAP_MAX + 2 * STALL_RUN_MAX + 2;
		if (op == MODE_LINE || op == MODE_PLOT) begin
			hot_x[hot_wr] = sx;
			hot_y[hot_wr] = sy;
			hot_wr = (hot_wr + 1) % HOT_N;
		end
		if (op == MODE_LINE) begin
			hot_x[hot_wr] = ex;
			hot_y[hot_wr] = ey;
			hot_wr = (hot_wr + 1) % HOT_N;
		end
	endtask

	task automatic flag_mismatch(string msg);
		err_count++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Request generation and end of run
	// ------------------------------------------------------------------
	initial begin : run_ctrl
		int n, i, pick, shape, sx, sy, ex, ey, d, sgx, sgy, reach_x, reach_y, h;
		int fills_left;
		logic [COLOR_W-1:0] argb;

		for (i = 0; i < FB_SIZE; i++) shadow_fb[i] = '0;
		for (i = 0; i < HOT_N; i++) begin
			hot_x[i] = 0;
			hot_y[i] = 0;
		end
		hot_wr      = 0;
		err_count   = 0;
		work_budget = 0;

		// Directed: reads of a fresh buffer, alpha extremes, every line class,
		// a degenerate line, ignored fields carrying junk, and whole-buffer fills.
		queue_req(MODE_READ, 0, 0, 0, 0, 32'hDEADBEEF);
		queue_req(MODE_READ, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFFFFFF);
		queue_req(MODE_PLOT, 0, 0, COORD_MAX, COORD_MAX, 32'hFFFFFFFF);
		queue_req(MODE_READ, 0, 0, 0, 0, 32'h00000000);
		queue_req(MODE_PLOT, COORD_MAX, COORD_MAX, 0, 0, 32'hFF123456);
		queue_req(MODE_PLOT, COORD_MAX, COORD_MAX, 0, 0, 32'h00ABCDEF);
		queue_req(MODE_PLOT, COORD_MAX, COORD_MAX, 0, 0, 32'h80FF00FF);
		queue_req(MODE_READ, COORD_MAX, COORD_MAX, 0, 0, 32'h5A5A5A5A);
		queue_req(MODE_LINE, 0, 10, COORD_MAX, 200, 32'hFF00FF00);
		queue_req(MODE_LINE, 200, 50, 10, 60, 32'hC0FF0000);
		queue_req(MODE_LINE, 5, 0, 40, COORD_MAX, 32'hFF0000FF);
		queue_req(MODE_LINE, 30, 200, 60, 20, 32'h7F808080);
		queue_req(MODE_LINE, 0, 0, COORD_MAX, COORD_MAX, 32'hFFFFFF00);
		queue_req(MODE_LINE, COORD_MAX, 0, 0, COORD_MAX, 32'h40102030);
		queue_req(MODE_LINE, 10, 50, 50, 10, 32'hFF00FFFF);
		queue_req(MODE_LINE, 77, 77, 77, 77, 32'hFFABCDEF);
		queue_req(MODE_LINE, 0, 128, COORD_MAX, 128, 32'hFFC0C0C0);
		queue_req(MODE_LINE, 128, COORD_MAX, 128, 0, 32'h01FFFFFF);
		queue_req(MODE_READ, 128, 128, 3, 9, 32'hFFFFFFFF);
		queue_req(MODE_READ, 77, 77, 0, 0, 32'h00000000);
		queue_req(MODE_FILL, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'h80102030);
		queue_req(MODE_READ, 0, 0, 0, 0, 32'h00000000);
		queue_req(MODE_FILL, 8'hAB, 8'hCD, 8'hEF, 8'h12, 32'hFF000000);
		queue_req(MODE_READ, 128, 128, 0, 0, 32'h00000000);
		queue_req(MODE_READ, 200, 17, 0, 0, 32'h00000000);

		// Random: mostly short lines and plots near each other, reads aimed
		// at freshly blended pixels, and a rare fill.
		fills_left = MAX_RAND_FILLS;
		for (n = 0; n < N_RANDOM; n++) begin
			pick = $urandom_range(0, 999);
			sx   = $urandom_range(0, COORD_MAX);
			sy   = $urandom_range(0, COORD_MAX);
			ex   = $urandom_range(0, COORD_MAX);
			ey   = $urandom_range(0, COORD_MAX);
			argb = rand_argb();
			if (pick < 480) begin
				shape = $urandom_range(0, 9);
				if (shape < 6) begin
					ex = near_coord(sx, 12);
					ey = near_coord(sy, 12);
				end else if (shape == 6) begin
					ey = sy;
				end else if (shape == 7) begin
					ex = sx;
				end else if (shape == 8) begin
					sgx     = $urandom_range(0, 1) ? 1 : -1;
					sgy     = $urandom_range(0, 1) ? 1 : -1;
					reach_x = (sgx > 0) ? COORD_MAX - sx : sx;
					reach_y = (sgy > 0) ? COORD_MAX - sy : sy;
					d       = $urandom_range(0, (reach_x < reach_y) ? reach_x : reach_y);
					ex      = sx + sgx * d;
					ey      = sy + sgy * d;
				end
				queue_req(MODE_LINE, sx, sy, ex, ey, argb);
			end else if (pick < 730) begin
				queue_req(MODE_PLOT, sx, sy, ex, ey, argb);
			end else if (pick >= 996 && fills_left > 0) begin
				fills_left--;
				queue_req(MODE_FILL, sx, sy, ex, ey, argb);
			end else begin
				if ($urandom_range(0, 9) < 7) begin
					h  = $urandom_range(0, HOT_N - 1);
					sx = hot_x[h];
					sy = hot_y[h];
					if ($urandom_range(0, 1)) begin
						sx = near_coord(sx, 2);
						sy = near_coord(sy, 2);
					end
				end
				queue_req(MODE_READ, sx, sy, ex, ey, argb);
			end
		end

		// The clearing pass after reset runs before the first request is taken.
		cycle_limit = 4 * (work_budget + FB_SIZE + RESET_CYCLES) + 10000;

		@(posedge arst_n);
		// Sample at the falling edge so the driver's updates have settled.
		do @(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: feed requests in bursts with random gaps between them.
	// Valid holds with a steady payload until the core takes the request.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			mode       <= '0;
			start_x    <= '0;
			start_y    <= '0;
			end_x      <= '0;
			end_y      <= '0;
			color      <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			// A request taken at this edge moves the shadow forward now, in order.
			if (in_valid && in_ready)
				expected_results.push_back(apply_request(cur_req));

			if (in_valid && !in_ready) begin
				// hold: request still waiting for the core
			end else if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				cur_req = pending_reqs.pop_front();
				mode    <= cur_req.op;
				start_x <= cur_req.sx;
				start_y <= cur_req.sy;
				end_x   <= cur_req.ex;
				end_y   <= cur_req.ey;
				color   <= cur_req.argb;
				in_valid <= 1'b1;
				if (burst_left != 0) begin
					burst_left--;
				end else if ($urandom_range(0, 3) == 0) begin
					// long back-to-back stretch with no idling
					burst_left = 40;
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(0, 7);
					gap_left   = $urandom_range(1, SEND_GAP_MAX);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: switch between always-ready runs, coin-flip runs and hard
	// stalls so back-pressure lands on every phase of the core's work.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_kind = 0;
			stall_left = 0;
		end else begin
			if (stall_left == 0) begin
				stall_kind = $urandom_range(0, 2);
				stall_left = $urandom_range(1, STALL_RUN_MAX);
			end
			stall_left--;
			case (stall_kind)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= 1'b0;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each taken result against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch($sformatf("result %0d unexpected: rgb=%06h count=%0d",
					result_idx, pixel_value, pixels_written));
			end else begin
				want = expected_results.pop_front();
				if (pixel_value !== want.rgb)
					flag_mismatch($sformatf("result %0d (%s) pixel_value %06h, want %06h",
						result_idx, want.op.name(), pixel_value, want.rgb));
				if (pixels_written !== want.count)
					flag_mismatch($sformatf("result %0d (%s) pixels_written %0d, want %0d",
						result_idx, want.op.name(), pixels_written, want.count));
			end
			result_idx++;
		end
	end

	// Watchdog: end the run once it exceeds the cycle limit set from the work budget.
	initial begin
		cycle_cnt  = 0;
		result_idx = 0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > cycle_limit) begin
			$display("timeout after %0d cycles, %0d requests unsent, %0d results owed",
				cycle_cnt, pending_reqs.size(), expected_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
